@@ rtl/life_step_pkg.sv @@
// Shared types, sizes and codes for the life automaton step unit.
// No dependencies; the interfaces, the step unit and the checker use this package.
`default_nettype none

package life_step_pkg;

   // Grid size
   localparam int GRID_COLS = 256;
   localparam int GRID_ROWS = 256;

   localparam int COL_W     = $clog2(GRID_COLS);
   localparam int ROW_W     = $clog2(GRID_ROWS);
   localparam int COL_CNT_W = $clog2(GRID_COLS + 1);
   localparam int ROW_CNT_W = $clog2(GRID_ROWS + 1);

   // Fixed field widths
   localparam int CFG_W     = 9;
   localparam int COORD_W   = 8;
   localparam int CMD_W     = 2;
   localparam int BIRTH_W   = 32;
   localparam int CSR_IDX_W = 1;

   // Common width for coordinate and size compares
   localparam int CMP_W0 = (COL_CNT_W > ROW_CNT_W) ? COL_CNT_W : ROW_CNT_W;
   localparam int CMP_W  = (CMP_W0 > CFG_W) ? CMP_W0 : CFG_W;

   typedef logic [COL_W-1:0]     col_idx_type;
   typedef logic [ROW_W-1:0]     row_idx_type;
   typedef logic [COL_CNT_W-1:0] col_cnt_type;
   typedef logic [ROW_CNT_W-1:0] row_cnt_type;
   typedef logic [CMP_W-1:0]     cmp_type;
   typedef logic [GRID_COLS-1:0] row_type;
   typedef logic [CFG_W-1:0]     cfg_type;
   typedef logic [COORD_W-1:0]   coord_type;
   typedef logic [CMD_W-1:0]     cmd_type;
   typedef logic [BIRTH_W-1:0]   birth_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // Commands
   localparam cmd_type CMD_WRITE   = 2'd0;
   localparam cmd_type CMD_READ    = 2'd1;
   localparam cmd_type CMD_ADVANCE = 2'd2;
   localparam cmd_type CMD_CLEAR   = 2'd3;

   // Register indexes
   localparam csr_idx_type REG_ACTIVE_WIDTH  = 1'b0;
   localparam csr_idx_type REG_ACTIVE_HEIGHT = 1'b1;

   localparam cfg_type ACTIVE_WIDTH_RST  = 9'd200;
   localparam cfg_type ACTIVE_HEIGHT_RST = 9'd180;

endpackage

`default_nettype wire

@@ rtl/life_step_req_if.sv @@
// Request channel: one command item per handshake.
// Depends on life_step_pkg for field types.
`default_nettype none

interface life_step_req_if;
   logic                      valid;
   logic                      ready;
   life_step_pkg::cmd_type    cmd;
   life_step_pkg::coord_type  cell_x;
   life_step_pkg::coord_type  cell_y;
   logic                      write_alive;

   modport source (output valid, output cmd, output cell_x, output cell_y,
                   output write_alive, input ready);
   modport sink   (input valid, input cmd, input cell_x, input cell_y,
                   input write_alive, output ready);
endinterface

`default_nettype wire

@@ rtl/life_step_rsp_if.sv @@
// Response channel: one result item per command.
// Depends on life_step_pkg for field types.
`default_nettype none

interface life_step_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      read_alive;
   life_step_pkg::birth_type  birth_total;
   logic                      status;

   modport source (output valid, output read_alive, output birth_total,
                   output status, input ready);
   modport sink   (input valid, input read_alive, input birth_total,
                   input status, output ready);
endinterface

`default_nettype wire

@@ rtl/life_step_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none

module life_step_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/life_automaton_step_unit.sv @@
// Life automaton step unit (B3/S23) over a row-wide grid RAM.
// Usage:
//   req_ch carries one command item (write cell, read cell, advance one
//   generation, clear birth counter); rsp_ch returns exactly one result item
//   per command, in order. csr_we/csr_index/csr_wdata set active width and
//   height; write them only while no command is in flight.
// Path from the accepting edge to the result register:
//   clear counter, write/read outside the active area, advance of an empty
//   area: straight to the output state
//   write/read cell: row read, modify and write back, then the output state
//   advance: each of the H active rows in turn, for active height H. The
//   row window rotates through all GRID_COLS columns, one cell per cycle
//   through the single neighbor-count unit; columns past the active width
//   keep their value. Each row adds a load and a write-back.
// One command is in work at a time; req_ch.ready is high only in idle, so the
// next command can be taken in the cycle after its predecessor's result is loaded.
// The result sits in an output register, so the next command can be taken
// while it waits; a further result then holds until rsp_ch.ready.
// Reset: the grid RAM is swept to dead one row per cycle, all GRID_ROWS rows,
// with req_ch.ready low; the birth counter clears and the size registers
// return to 200 x 180. CSR writes are taken during the sweep.
// Depends on life_step_pkg, life_step_req_if, life_step_rsp_if,
// life_step_ram.
`default_nettype none

module life_automaton_step_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   life_step_req_if.sink                    req_ch,
   life_step_rsp_if.source                  rsp_ch,
   input  wire logic                        csr_we,
   input  wire life_step_pkg::csr_idx_type  csr_index,
   input  wire life_step_pkg::cfg_type      csr_wdata
);

   localparam logic [3:0] S_CLEAR      = 4'd0;
   localparam logic [3:0] S_IDLE       = 4'd1;
   localparam logic [3:0] S_CELL_DAT   = 4'd2;
   localparam logic [3:0] S_ADV_LOAD0  = 4'd3;
   localparam logic [3:0] S_ADV_LOADN  = 4'd4;
   localparam logic [3:0] S_ADV_CELL   = 4'd5;
   localparam logic [3:0] S_ADV_ROWEND = 4'd6;
   localparam logic [3:0] S_OUT        = 4'd7;

   logic [3:0] state_ff, state_in;

   life_step_pkg::cfg_type     aw_ff, aw_in, ah_ff, ah_in;
   life_step_pkg::col_cnt_type ew;
   life_step_pkg::row_cnt_type eh;

   life_step_pkg::cmd_type     cmd_ff, cmd_in;
   life_step_pkg::coord_type   cx_ff, cx_in, cy_ff, cy_in;
   logic                       wv_ff, wv_in;

   life_step_pkg::row_type     prior_ff, prior_in;
   life_step_pkg::row_type     cur_ff, cur_in;
   life_step_pkg::row_type     nxt_ff, nxt_in;
   life_step_pkg::row_type     new_ff, new_in;
   life_step_pkg::col_idx_type x_ff, x_in;
   life_step_pkg::row_cnt_type y_ff, y_in;

   life_step_pkg::birth_type   birth_ff, birth_in;
   logic                       pend_read_ff, pend_read_in;
   logic                       pend_status_ff, pend_status_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_read_ff, rsp_read_in;
   life_step_pkg::birth_type   rsp_birth_ff, rsp_birth_in;
   logic                       rsp_status_ff, rsp_status_in;

   // RAM port
   logic                       ram_we;
   life_step_pkg::row_idx_type ram_waddr, ram_raddr;
   life_step_pkg::row_type     ram_wdata, ram_rdata;

   // Neighbor-count unit
   logic                       has_l, has_r, has_up, has_dn, in_col;
   logic [7:0]                 nb;
   logic [3:0]                 ncount;
   logic                       alive, next_alive, birth;
   logic                       last_col, last_row;

   logic                       req_acc, in_area, cell_bit;

   // Effective active size, saturated to the grid
   always_comb begin
      if (life_step_pkg::cmp_type'(aw_ff) > life_step_pkg::cmp_type'(life_step_pkg::GRID_COLS)) begin
         ew = life_step_pkg::col_cnt_type'(life_step_pkg::GRID_COLS);
      end else begin
         ew = life_step_pkg::col_cnt_type'(aw_ff);
      end
      if (life_step_pkg::cmp_type'(ah_ff) > life_step_pkg::cmp_type'(life_step_pkg::GRID_ROWS)) begin
         eh = life_step_pkg::row_cnt_type'(life_step_pkg::GRID_ROWS);
      end else begin
         eh = life_step_pkg::row_cnt_type'(ah_ff);
      end
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign in_area = (life_step_pkg::cmp_type'(req_ch.cell_x) < life_step_pkg::cmp_type'(ew))
                 && (life_step_pkg::cmp_type'(req_ch.cell_y) < life_step_pkg::cmp_type'(eh));

   // One cell of the generation: the row buffers rotate so that column x sits
   // at bit 0, x+1 at bit 1 and x-1 at the top bit
   assign has_l    = (x_ff != '0);
   assign has_r    = (life_step_pkg::col_cnt_type'(x_ff) + 1'b1) < ew;
   assign has_up   = (y_ff != '0);
   assign has_dn   = (y_ff + 1'b1) < eh;
   assign in_col   = life_step_pkg::col_cnt_type'(x_ff) < ew;
   assign last_col = (x_ff == life_step_pkg::col_idx_type'(life_step_pkg::GRID_COLS - 1));
   assign last_row = (y_ff + 1'b1) == eh;

   assign nb = {has_up & has_l & prior_ff[life_step_pkg::GRID_COLS-1],
                has_up & prior_ff[0], has_up & has_r & prior_ff[1],
                has_l & cur_ff[life_step_pkg::GRID_COLS-1], has_r & cur_ff[1],
                has_dn & has_l & nxt_ff[life_step_pkg::GRID_COLS-1],
                has_dn & nxt_ff[0], has_dn & has_r & nxt_ff[1]};

   always_comb begin
      ncount = '0;
      for (int i = 0; i < 8; i++) begin
         ncount = ncount + {3'b000, nb[i]};
      end
   end

   assign alive      = cur_ff[0];
   assign birth      = !alive && (ncount == 4'd3);
   assign next_alive = alive ? ((ncount == 4'd2) || (ncount == 4'd3)) : (ncount == 4'd3);
   assign cell_bit   = ram_rdata[life_step_pkg::col_idx_type'(cx_ff)];

   always_comb begin
      state_in       = state_ff;
      aw_in          = aw_ff;
      ah_in          = ah_ff;
      cmd_in         = cmd_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      wv_in          = wv_ff;
      prior_in       = prior_ff;
      cur_in         = cur_ff;
      nxt_in         = nxt_ff;
      new_in         = new_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      birth_in       = birth_ff;
      pend_read_in   = pend_read_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_read_in    = rsp_read_ff;
      rsp_birth_in   = rsp_birth_ff;
      rsp_status_in  = rsp_status_ff;
      ram_we         = 1'b0;
      ram_waddr      = life_step_pkg::row_idx_type'(y_ff);
      ram_wdata      = new_ff;
      ram_raddr      = life_step_pkg::row_idx_type'(req_ch.cell_y);

      if (csr_we) begin
         unique case (csr_index)
            life_step_pkg::REG_ACTIVE_WIDTH:  aw_in = csr_wdata;
            life_step_pkg::REG_ACTIVE_HEIGHT: ah_in = csr_wdata;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            y_in      = y_ff + 1'b1;
            if (y_ff == life_step_pkg::row_cnt_type'(life_step_pkg::GRID_ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.cmd == life_step_pkg::CMD_ADVANCE) begin
               ram_raddr = '0;
            end
            if (req_acc) begin
               cmd_in         = req_ch.cmd;
               cx_in          = req_ch.cell_x;
               cy_in          = req_ch.cell_y;
               wv_in          = req_ch.write_alive;
               y_in           = '0;
               pend_read_in   = 1'b0;
               pend_status_in = 1'b0;
               case (req_ch.cmd) inside
                  life_step_pkg::CMD_WRITE, life_step_pkg::CMD_READ: begin
                     if (in_area) begin
                        state_in = S_CELL_DAT;
                     end else begin
                        pend_status_in = 1'b1;
                        state_in       = S_OUT;
                     end
                  end
                  life_step_pkg::CMD_ADVANCE: begin
                     if ((ew == '0) || (eh == '0)) begin
                        state_in = S_OUT;
                     end else begin
                        state_in = S_ADV_LOAD0;
                     end
                  end
                  default: begin
                     birth_in = '0;
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_CELL_DAT: begin
            // read-modify-write of the addressed row on a write; a read only picks the bit
            ram_waddr = life_step_pkg::row_idx_type'(cy_ff);
            ram_wdata = ram_rdata;
            ram_wdata[life_step_pkg::col_idx_type'(cx_ff)] = wv_ff;
            ram_we    = (cmd_ff == life_step_pkg::CMD_WRITE);
            pend_read_in = (cmd_ff == life_step_pkg::CMD_READ) && cell_bit;
            state_in  = S_OUT;
         end
         S_ADV_LOAD0: begin
            cur_in    = ram_rdata;
            new_in    = ram_rdata;
            ram_raddr = life_step_pkg::row_idx_type'(1);
            state_in  = S_ADV_LOADN;
         end
         S_ADV_LOADN: begin
            nxt_in   = ram_rdata;
            x_in     = '0;
            state_in = S_ADV_CELL;
         end
         S_ADV_CELL: begin
            // a full turn through all GRID_COLS columns leaves every row back in place
            prior_in = {prior_ff[0], prior_ff[life_step_pkg::GRID_COLS-1:1]};
            cur_in   = {cur_ff[0], cur_ff[life_step_pkg::GRID_COLS-1:1]};
            nxt_in   = {nxt_ff[0], nxt_ff[life_step_pkg::GRID_COLS-1:1]};
            new_in   = {in_col ? next_alive : alive, new_ff[life_step_pkg::GRID_COLS-1:1]};
            if (in_col && birth) begin
               birth_in = birth_ff + 1'b1;
            end
            x_in = x_ff + 1'b1;
            if (last_col) begin
               state_in = S_ADV_ROWEND;
            end
         end
         S_ADV_ROWEND: begin
            // write back row y, shift the window down one row
            ram_we    = 1'b1;
            prior_in  = cur_ff;
            cur_in    = nxt_ff;
            new_in    = nxt_ff;
            ram_raddr = life_step_pkg::row_idx_type'(y_ff + 2'd2);
            if (last_row) begin
               state_in = S_OUT;
            end else begin
               y_in     = y_ff + 1'b1;
               state_in = S_ADV_LOADN;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_read_in   = pend_read_ff;
               rsp_status_in = pend_status_ff;
               rsp_birth_in  = birth_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         y_ff         <= '0;
         aw_ff        <= life_step_pkg::ACTIVE_WIDTH_RST;
         ah_ff        <= life_step_pkg::ACTIVE_HEIGHT_RST;
         birth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         y_ff         <= y_in;
         aw_ff        <= aw_in;
         ah_ff        <= ah_in;
         birth_ff     <= birth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      cx_ff          <= cx_in;
      cy_ff          <= cy_in;
      wv_ff          <= wv_in;
      prior_ff       <= prior_in;
      cur_ff         <= cur_in;
      nxt_ff         <= nxt_in;
      new_ff         <= new_in;
      x_ff           <= x_in;
      pend_read_ff   <= pend_read_in;
      pend_status_ff <= pend_status_in;
      rsp_read_ff    <= rsp_read_in;
      rsp_birth_ff   <= rsp_birth_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_alive  = rsp_read_ff;
   assign rsp_ch.birth_total = rsp_birth_ff;
   assign rsp_ch.status      = rsp_status_ff;

   life_step_ram #(
      .WIDTH (life_step_pkg::GRID_COLS),
      .DEPTH (life_step_pkg::GRID_ROWS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (1'b1),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

`default_nettype wire

@@ rtl/life_step_checker.sv @@
// Port-level checks for life_automaton_step_unit, attached by bind.
// Depends on life_step_pkg and the top level's channel interfaces.
`default_nettype none

module life_step_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic                      rsp_read_alive,
   input wire life_step_pkg::birth_type  rsp_birth_total,
   input wire logic                      rsp_status
);

   logic       in_acc, out_acc;
   logic [1:0] open_ff, open_in;

   assign in_acc  = req_valid && req_ready;
   assign out_acc = rsp_valid && rsp_ready;

   // items accepted but not yet delivered
   always_comb begin
      open_in = open_ff;
      if (in_acc && !out_acc) begin
         open_in = open_ff + 1'b1;
      end else if (out_acc && !in_acc) begin
         open_in = open_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_birth_total)
         && $stable(rsp_read_alive) && $stable(rsp_status))
      else $error("result item changed while stalled");

   a_sweep_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("command taken during grid clearing sweep");

   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("result item without an accepted command");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      in_acc |-> open_ff <= 2'd1)
      else $error("command taken while another is still in work");

   a_flag_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> !rsp_read_alive)
      else $error("flagged coordinate returned a live cell");

endmodule

bind life_automaton_step_unit life_step_checker u_life_step_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_read_alive  (rsp_ch.read_alive),
   .rsp_birth_total (rsp_ch.birth_total),
   .rsp_status      (rsp_ch.status)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for life_automaton_step_unit (B3/S23 grid engine).
// Keeps a shadow copy of the grid, birth counter and size registers and checks
// every result item in order. Depends on life_step_pkg and both channel interfaces.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Limit is about 4x the longest, full-grid advance, to allow for stalls.
   localparam int IDLE_LIMIT  = 270_000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic                     read_alive;
      life_step_pkg::birth_type birth_total;
      logic                     status;
   } life_result_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   life_step_pkg::csr_idx_type csr_index;
   life_step_pkg::cfg_type     csr_wdata;

   life_step_req_if req_ch ();
   life_step_rsp_if rsp_ch ();

   life_automaton_step_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow state of the block
   bit shadow_grid [life_step_pkg::GRID_ROWS][life_step_pkg::GRID_COLS];
   bit prev_gen    [life_step_pkg::GRID_ROWS][life_step_pkg::GRID_COLS];
   life_step_pkg::birth_type shadow_births;
   life_step_pkg::cfg_type   shadow_width;
   life_step_pkg::cfg_type   shadow_height;

   life_result_type pending_results [$];

   int errors;
   int sent_count;
   int checked_count;
   int advance_count;
   int idle_cycles;
   int hold_left;
   int stall_left;
   bit hold_request;
   bit steady_mode;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int clamp_span(life_step_pkg::cfg_type v, int lim);
      return (int'(v) > lim) ? lim : int'(v);
   endfunction

   // One generation over the active area; everything outside counts as dead.
   function automatic void advance_generation();
      int w, h, n, yy, xx;
      w = clamp_span(shadow_width, life_step_pkg::GRID_COLS);
      h = clamp_span(shadow_height, life_step_pkg::GRID_ROWS);
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++)
            prev_gen[y][x] = shadow_grid[y][x];
      for (int y = 0; y < h; y++) begin
         for (int x = 0; x < w; x++) begin
            n = 0;
            for (int dy = -1; dy <= 1; dy++) begin
               for (int dx = -1; dx <= 1; dx++) begin
                  yy = y + dy;
                  xx = x + dx;
                  if ((dy != 0 || dx != 0) && yy >= 0 && yy < h && xx >= 0 && xx < w)
                     n += prev_gen[yy][xx];
               end
            end
            if (!prev_gen[y][x]) begin
               if (n == 3) begin
                  shadow_grid[y][x] = 1'b1;
                  shadow_births++;
               end
            end else if (n < 2 || n > 3) begin
               shadow_grid[y][x] = 1'b0;
            end
         end
      end
   endfunction

   function automatic life_result_type predict_command(life_step_pkg::cmd_type c,
                                                       life_step_pkg::coord_type x,
                                                       life_step_pkg::coord_type y,
                                                       logic alive);
      life_result_type r;
      int w, h;
      w = clamp_span(shadow_width, life_step_pkg::GRID_COLS);
      h = clamp_span(shadow_height, life_step_pkg::GRID_ROWS);
      r = '0;
      case (c) inside
         life_step_pkg::CMD_WRITE, life_step_pkg::CMD_READ: begin
            if (x >= w || y >= h) r.status = 1'b1;
            else if (c == life_step_pkg::CMD_WRITE) shadow_grid[y][x] = alive;
            else r.read_alive = shadow_grid[y][x];
         end
         life_step_pkg::CMD_ADVANCE: advance_generation();
         life_step_pkg::CMD_CLEAR:   shadow_births = '0;
         default: ;
      endcase
      r.birth_total = shadow_births;
      return r;
   endfunction

   task automatic send_command(life_step_pkg::cmd_type c, life_step_pkg::coord_type x,
                               life_step_pkg::coord_type y, logic alive);
      int gap;
      gap = steady_mode ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
      @(negedge clock);
      req_ch.valid       = 1'b1;
      req_ch.cmd         = c;
      req_ch.cell_x      = x;
      req_ch.cell_y      = y;
      req_ch.write_alive = alive;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_results.push_back(predict_command(c, x, y, alive));
      sent_count++;
      if (c == life_step_pkg::CMD_ADVANCE) advance_count++;
   endtask

   // Withdraws the last offered item first so it is not taken twice
   task automatic wait_for_idle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Only called with nothing in flight
   task automatic set_area(life_step_pkg::cfg_type w, life_step_pkg::cfg_type h);
      @(negedge clock);
      req_ch.valid = 1'b0;
      csr_we    = 1'b1;
      csr_index = life_step_pkg::REG_ACTIVE_WIDTH;
      csr_wdata = w;
      @(negedge clock);
      csr_index = life_step_pkg::REG_ACTIVE_HEIGHT;
      csr_wdata = h;
      @(negedge clock);
      csr_we = 1'b0;
      shadow_width  = w;
      shadow_height = h;
   endtask

   // Reset sizes 200 x 180: corners, just outside, and an ignored write
   task automatic test_reset_area();
      send_command(life_step_pkg::CMD_READ, 8'd0, 8'd0, 1'b0);
      send_command(life_step_pkg::CMD_READ, 8'd199, 8'd179, 1'b0);
      send_command(life_step_pkg::CMD_READ, 8'd200, 8'd0, 1'b0);
      send_command(life_step_pkg::CMD_READ, 8'd0, 8'd180, 1'b0);
      send_command(life_step_pkg::CMD_WRITE, 8'd255, 8'd255, 1'b1);
   endtask

   // Oversized width saturates to the full grid; one full-grid advance
   task automatic test_full_grid();
      wait_for_idle();
      set_area(9'd511, 9'd256);
      send_command(life_step_pkg::CMD_WRITE, 8'd255, 8'd255, 1'b1);
      send_command(life_step_pkg::CMD_WRITE, 8'd254, 8'd255, 1'b1);
      send_command(life_step_pkg::CMD_WRITE, 8'd255, 8'd254, 1'b1);
      send_command(life_step_pkg::CMD_ADVANCE, 8'd0, 8'd0, 1'b0);
      send_command(life_step_pkg::CMD_READ, 8'd255, 8'd255, 1'b0);
      send_command(life_step_pkg::CMD_READ, 8'd254, 8'd254, 1'b0);
   endtask

   // Live cells just past the right edge must not feed the edge column
   task automatic test_outside_neighbors();
      send_command(life_step_pkg::CMD_WRITE, 8'd200, 8'd10, 1'b1);
      send_command(life_step_pkg::CMD_WRITE, 8'd200, 8'd11, 1'b1);
      send_command(life_step_pkg::CMD_WRITE, 8'd200, 8'd12, 1'b1);
      send_command(life_step_pkg::CMD_WRITE, 8'd199, 8'd11, 1'b1);
      wait_for_idle();
      set_area(life_step_pkg::ACTIVE_WIDTH_RST, life_step_pkg::ACTIVE_HEIGHT_RST);
      send_command(life_step_pkg::CMD_ADVANCE, 8'd0, 8'd0, 1'b0);
      send_command(life_step_pkg::CMD_READ, 8'd199, 8'd11, 1'b0);
   endtask

   // Empty area: everything flagged, advance is a no-op
   task automatic test_zero_area();
      wait_for_idle();
      set_area(9'd0, 9'd0);
      send_command(life_step_pkg::CMD_WRITE, 8'd0, 8'd0, 1'b1);
      send_command(life_step_pkg::CMD_READ, 8'd0, 8'd0, 1'b0);
      send_command(life_step_pkg::CMD_ADVANCE, 8'd0, 8'd0, 1'b0);
   endtask

   // Blinker on the top edge of a small area, then clear the counter
   task automatic test_blinker();
      wait_for_idle();
      set_area(9'd5, 9'd5);
      send_command(life_step_pkg::CMD_WRITE, 8'd0, 8'd1, 1'b1);
      send_command(life_step_pkg::CMD_WRITE, 8'd1, 8'd1, 1'b1);
      send_command(life_step_pkg::CMD_WRITE, 8'd2, 8'd1, 1'b1);
      send_command(life_step_pkg::CMD_ADVANCE, 8'd0, 8'd0, 1'b0);
      send_command(life_step_pkg::CMD_READ, 8'd1, 8'd0, 1'b0);
      send_command(life_step_pkg::CMD_CLEAR, 8'd0, 8'd0, 1'b0);
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      wait_for_idle();
      set_area(9'd16, 9'd16);
      @(posedge clock);
      hold_request = 1'b1;
      steady_mode  = 1'b1;
      for (int i = 0; i < 8; i++)
         send_command(i[0] ? life_step_pkg::CMD_READ : life_step_pkg::CMD_WRITE,
                      life_step_pkg::coord_type'(i), life_step_pkg::coord_type'(i + 1),
                      1'b1);
      steady_mode = 1'b0;
      wait_for_idle();
   endtask

   task automatic pick_random_area(output life_step_pkg::cfg_type w,
                                   output life_step_pkg::cfg_type h);
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         w = life_step_pkg::cfg_type'($urandom_range(1, 12));
         h = life_step_pkg::cfg_type'($urandom_range(1, 12));
      end else if (r < 78) begin
         w = 9'd256;
         h = life_step_pkg::cfg_type'($urandom_range(1, 3));
      end else if (r < 86) begin
         w = life_step_pkg::cfg_type'($urandom_range(1, 3));
         h = 9'd256;
      end else if (r < 94) begin
         w = life_step_pkg::cfg_type'($urandom_range(257, 511));
         h = life_step_pkg::cfg_type'($urandom_range(1, 4));
      end else begin
         w = life_step_pkg::cfg_type'($urandom_range(0, 1) ? 0 : 7);
         h = life_step_pkg::cfg_type'($urandom_range(0, 1) ? 0 : 7);
      end
   endtask

   // Seed, evolve and probe patterns; a tenth of the items is raw noise
   task automatic test_random(int phases, int per_phase);
      life_step_pkg::cfg_type   w, h;
      int                       ew, eh, r;
      life_step_pkg::coord_type x, y;
      for (int p = 0; p < phases; p++) begin
         wait_for_idle();
         pick_random_area(w, h);
         set_area(w, h);
         ew = clamp_span(w, life_step_pkg::GRID_COLS);
         eh = clamp_span(h, life_step_pkg::GRID_ROWS);
         steady_mode = (p == 2);
         for (int i = 0; i < per_phase; i++) begin
            r = $urandom_range(0, 99);
            if (ew > 0 && eh > 0 && r < 90) begin
               x = life_step_pkg::coord_type'($urandom_range(0, ew - 1));
               y = life_step_pkg::coord_type'($urandom_range(0, eh - 1));
            end else begin
               x = life_step_pkg::coord_type'($urandom_range(0, 255));
               y = life_step_pkg::coord_type'($urandom_range(0, 255));
            end
            if (r < 45)
               send_command(life_step_pkg::CMD_WRITE, x, y, $urandom_range(0, 99) < 60);
            else if (r < 65)
               send_command(life_step_pkg::CMD_READ, x, y, 1'($urandom_range(0, 1)));
            else if (r < 85)
               send_command(life_step_pkg::CMD_ADVANCE, x, y, 1'($urandom_range(0, 1)));
            else if (r < 90)
               send_command(life_step_pkg::CMD_CLEAR, x, y, 1'($urandom_range(0, 1)));
            else
               send_command(life_step_pkg::cmd_type'($urandom_range(0, 3)), x, y,
                            1'($urandom_range(0, 1)));
         end
         steady_mode = 1'b0;
      end
   endtask

   // Result receiver with random stalls and a counted long hold-off
   initial begin
      rsp_ch.ready = 1'b0;
      hold_left    = 0;
      stall_left   = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready = 1'b1;
            if (!steady_mode) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      life_result_type exp_r;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result item with nothing expected", $time);
            errors++;
         end else begin
            exp_r = pending_results.pop_front();
            checked_count++;
            if (rsp_ch.read_alive !== exp_r.read_alive) begin
               $display("%0t: read_alive expected %0d actual %0d", $time,
                        exp_r.read_alive, rsp_ch.read_alive);
               errors++;
            end
            if (rsp_ch.birth_total !== exp_r.birth_total) begin
               $display("%0t: birth_total expected %0d actual %0d", $time,
                        exp_r.birth_total, rsp_ch.birth_total);
               errors++;
            end
            if (rsp_ch.status !== exp_r.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_r.status, rsp_ch.status);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = life_step_pkg::REG_ACTIVE_WIDTH;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.cmd         = life_step_pkg::CMD_WRITE;
      req_ch.cell_x      = '0;
      req_ch.cell_y      = '0;
      req_ch.write_alive = 1'b0;
      shadow_births      = '0;
      shadow_width       = life_step_pkg::ACTIVE_WIDTH_RST;
      shadow_height      = life_step_pkg::ACTIVE_HEIGHT_RST;
      errors             = 0;
      sent_count         = 0;
      checked_count      = 0;
      advance_count      = 0;
      idle_cycles        = 0;
      hold_request       = 1'b0;
      steady_mode        = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_area();
      test_full_grid();
      test_outside_neighbors();
      test_zero_area();
      test_blinker();
      test_backpressure();
      test_random(6, 11);

      @(negedge clock);
      req_ch.valid = 1'b0;
      wait_for_idle();
      repeat (20) @(posedge clock);

      if (pending_results.size() != 0) begin
         $display("%0t: %0d result items never arrived", $time, pending_results.size());
         errors++;
      end
      $display("Ran %0d commands (%0d generation steps), %0d result items compared,",
               sent_count, advance_count, checked_count);
      $display("over areas from empty to full grid with saturated sizes and stalls.");
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/life_step_pkg.sv
rtl/life_step_req_if.sv
rtl/life_step_rsp_if.sv
rtl/life_step_ram.sv
rtl/life_automaton_step_unit.sv
rtl/life_step_checker.sv
tb/testbench.sv
